### src/pctd_pkg.sv
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types and constants of the prefix-code tree decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

  // table geometry
  localparam int MAX_NODES    = 512;
  localparam int NODE_W       = $clog2(MAX_NODES);
  localparam int CNT_W        = $clog2(MAX_NODES + 1);
  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_BITS  = 8;

  // field widths
  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;
  localparam int BIT_IDX_W = $clog2(CODE_W);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DECODE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SYMBOL  = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_FRESH,
    S_DRD,
    S_DEVAL
  } state_t;

  // one node of the tree as held in the node table
  typedef struct packed {
    logic [NODE_W-1:0]      left;
    logic [NODE_W-1:0]      right;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

endpackage

### src/pctd_if.sv
// ----------------------------------------------------------------------------
// pctd_in_if / pctd_out_if
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
interface pctd_in_if;
  import pctd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              bit_req;

  modport source (output valid, opcode, symbol, code_bits, code_length, bit_req,
                  input ready);
  modport sink   (input valid, opcode, symbol, code_bits, code_length, bit_req,
                  output ready);
endinterface

interface pctd_out_if;
  import pctd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYM_W-1:0]    symbol_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, symbol_res, status, input ready);
  modport sink   (input valid, symbol_res, status, output ready);
endinterface

### src/prefix_code_tree_decoder_unit.sv
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder_unit
// Prefix-code tree builder and bit-serial decoder on a node table.
// ----------------------------------------------------------------------------
// Items are taken one at a time; the block is ready only between items. All
// tree walking goes through one node-table port (one read or one write per
// cycle, read data registered), so each tree level is walked as a read state
// followed by an evaluate state. An insert walks existing levels that way,
// adds a fresh-node write per level that has to be allocated, and ends with
// a read and a store of the symbol. A decode bit reads and evaluates the
// current node and ends there when its branch is missing; when it steps onto
// a node it also reads and evaluates that node, whether that node is an
// inner node or a leaf that returns the symbol. The root lives in
// flip-flops, so clear and reset need no pass over the table. A result
// waits in an output register; the next item is accepted while it waits,
// and a further result holds its walk until the register drains.
module prefix_code_tree_decoder_unit (
  input  logic                 clk,
  input  logic                 rst,
  pctd_in_if.sink              in_ch,
  pctd_out_if.source           out_ch
);
  import pctd_pkg::*;

  // node table, entry 0 unused (root is in registers)
  node_t tree_mem [MAX_NODES];

  state_t                  state, state_next;
  op_t                     op, op_next;
  logic [NODE_W-1:0]       node, node_next;
  logic [LEN_W-1:0]        bits_left, bits_left_next;
  logic [CODE_W-1:0]       code, code_next;
  logic [SYMBOL_BITS-1:0]  sym, sym_next;
  logic                    bit_q, bit_q_next;
  logic [NODE_W-1:0]       current_node, current_node_next;
  logic [CNT_W-1:0]        nodes_used, nodes_used_next;
  logic [NODE_W-1:0]       root_left, root_left_next;
  logic [NODE_W-1:0]       root_right, root_right_next;
  node_t                   rd_q;
  logic                    out_valid, out_valid_next;
  logic [SYM_W-1:0]        out_sym, out_sym_next;
  status_t                 out_status, out_status_next;

  logic                    rd_en;
  logic                    wr_en;
  logic [NODE_W-1:0]       wr_addr;
  node_t                   wr_data;

  node_t                   cur_entry;
  logic [BIT_IDX_W-1:0]    bit_idx;
  logic                    walk_bit;
  logic [NODE_W-1:0]       child;
  logic                    table_full;
  logic                    out_free;
  logic                    accept;
  logic [LEN_W-1:0]        len_sat;

  // node under evaluation: root from registers, others from the table
  always_comb begin
    if (node == '0) begin
      cur_entry = '{left: root_left, right: root_right, sym: '0};
    end else begin
      cur_entry = rd_q;
    end
  end

  assign bit_idx    = BIT_IDX_W'(bits_left - LEN_W'(1));
  assign walk_bit   = (op == OP_DECODE) ? bit_q : code[bit_idx];
  assign child      = walk_bit ? cur_entry.right : cur_entry.left;
  assign table_full = (nodes_used == CNT_W'(MAX_NODES));
  assign out_free   = !out_valid || out_ch.ready;
  assign accept     = in_ch.valid && in_ch.ready;
  assign len_sat    = (in_ch.code_length > LEN_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : in_ch.code_length;

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.symbol_res = out_sym;
  assign out_ch.status     = out_status;

  // sequencer: next state, table access and result
  always_comb begin
    state_next        = state;
    op_next           = op;
    node_next         = node;
    bits_left_next    = bits_left;
    code_next         = code;
    sym_next          = sym;
    bit_q_next        = bit_q;
    current_node_next = current_node;
    nodes_used_next   = nodes_used;
    root_left_next    = root_left;
    root_right_next   = root_right;
    out_valid_next    = out_valid && !out_ch.ready;
    out_sym_next      = out_sym;
    out_status_next   = out_status;
    rd_en             = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = node;
    wr_data           = cur_entry;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next = op_t'(in_ch.opcode);
          case (op_t'(in_ch.opcode))
            OP_INSERT: begin
              node_next      = '0;
              bits_left_next = len_sat;
              code_next      = in_ch.code_bits;
              sym_next       = SYMBOL_BITS'(in_ch.symbol);
              state_next     = S_RD;
            end
            OP_DECODE: begin
              node_next  = current_node;
              bit_q_next = in_ch.bit_req;
              state_next = S_RD;
            end
            OP_CLEAR: begin
              root_left_next    = '0;
              root_right_next   = '0;
              nodes_used_next   = CNT_W'(1);
              current_node_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        rd_en      = 1'b1;
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (op == OP_DECODE) begin
          // one decode step from the current node
          if (child == '0) begin
            if (out_free) begin
              out_valid_next    = 1'b1;
              out_sym_next      = '0;
              out_status_next   = ST_INVALID;
              current_node_next = '0;
              state_next        = S_IDLE;
            end
          end else begin
            node_next  = child;
            state_next = S_DRD;
          end
        end else if (bits_left == '0) begin
          // end of code: store the symbol, root keeps none
          if (node != '0) begin
            wr_en   = 1'b1;
            wr_data = '{left: cur_entry.left, right: cur_entry.right, sym: sym};
          end
          state_next = S_IDLE;
        end else if (child != '0) begin
          node_next      = child;
          bits_left_next = bits_left - LEN_W'(1);
          state_next     = S_RD;
        end else if (table_full) begin
          if (out_free) begin
            out_valid_next  = 1'b1;
            out_sym_next    = '0;
            out_status_next = ST_FULL;
            state_next      = S_IDLE;
          end
        end else begin
          // link a fresh node into the missing slot
          if (node == '0) begin
            if (walk_bit) begin
              root_right_next = nodes_used[NODE_W-1:0];
            end else begin
              root_left_next = nodes_used[NODE_W-1:0];
            end
          end else begin
            wr_en = 1'b1;
            if (walk_bit) begin
              wr_data.right = nodes_used[NODE_W-1:0];
            end else begin
              wr_data.left = nodes_used[NODE_W-1:0];
            end
          end
          nodes_used_next = nodes_used + CNT_W'(1);
          node_next       = nodes_used[NODE_W-1:0];
          state_next      = S_FRESH;
        end
      end

      S_FRESH: begin
        // fresh node starts with no children and a zero symbol
        wr_en          = 1'b1;
        wr_data        = '0;
        bits_left_next = bits_left - LEN_W'(1);
        state_next     = S_RD;
      end

      S_DRD: begin
        rd_en      = 1'b1;
        state_next = S_DEVAL;
      end

      S_DEVAL: begin
        if (rd_q.left == '0 && rd_q.right == '0) begin
          if (out_free) begin
            out_valid_next    = 1'b1;
            out_sym_next      = SYM_W'(rd_q.sym);
            out_status_next   = ST_SYMBOL;
            current_node_next = '0;
            state_next        = S_IDLE;
          end
        end else begin
          current_node_next = node;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      current_node <= '0;
      nodes_used   <= CNT_W'(1);
      root_left    <= '0;
      root_right   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      current_node <= current_node_next;
      nodes_used   <= nodes_used_next;
      root_left    <= root_left_next;
      root_right   <= root_right_next;
      out_valid    <= out_valid_next;
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    node       <= node_next;
    bits_left  <= bits_left_next;
    code       <= code_next;
    sym        <= sym_next;
    bit_q      <= bit_q_next;
    out_sym    <= out_sym_next;
    out_status <= out_status_next;
  end

  // node table, one access per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= tree_mem[node];
    end
  end

`ifndef SYNTHESIS
  // the fill count stays within the table
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    nodes_used >= CNT_W'(1) && nodes_used <= CNT_W'(MAX_NODES))
    else $error("node fill count out of range");

  // a clear item empties the tree by the next cycle
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.opcode == OP_CLEAR) |=>
      (nodes_used == CNT_W'(1) && root_left == '0 && root_right == '0
       && current_node == '0))
    else $error("clear did not empty the tree");

  // error results carry a zero symbol
  a_err_sym: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_SYMBOL) |-> out_sym == '0)
    else $error("error result with nonzero symbol");

  // a decode result always leaves the walk at the root
  a_root_return: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_status != ST_FULL) |-> current_node == '0)
    else $error("decode result without return to root");
`endif

endmodule
